// File: src/msjd_pkg.sv
package msjd_pkg;

  localparam int MAX_SERVERS = 8;
  localparam int QUEUE_DEPTH = 64;
  localparam int TAG_BITS = 16;

  localparam int SRV_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int QADDR_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_W = $clog2(MAX_SERVERS + 1);

  localparam int KIND_W = 3;
  localparam int IDX_OUT_W = 3;
  localparam int WAIT_W = 7;
  localparam int BUSY_OUT_W = 4;

  localparam int SRV_CFG_W = 4;
  localparam int LIMIT_W = 7;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SERVERS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLED = 2'd2;

  localparam logic [KIND_W-1:0] EV_STARTED = 3'd0;
  localparam logic [KIND_W-1:0] EV_QUEUED = 3'd1;
  localparam logic [KIND_W-1:0] EV_DROPPED = 3'd2;
  localparam logic [KIND_W-1:0] EV_DEPART_IDLE = 3'd3;
  localparam logic [KIND_W-1:0] EV_DEPART_NEXT = 3'd4;

  typedef struct packed {
    logic we;
    logic busy;
    logic [SRV_W-1:0] idx;
    logic [TAG_BITS-1:0] job;
  } srv_cmd_t;

  typedef struct packed {
    logic busy;
    logic match;
  } srv_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

// File: src/multi_server_job_dispatcher.sv
// Channel  Handshake             Payload
// cfg      cfg_write             cfg_index, cfg_data
// in       in_valid / in_stall   job_tag
// out      out_valid / out_stall event_kind, server_index, departed_tag, started_tag,
//                                waiting_count, busy_count
//
// For each job the shared tag comparator steps through the active servers, from one up to
// MAX_SERVERS of them, until it finds a match or reaches the last active server.
// The DONE state commits server and FIFO updates and loads the output register.
// The DONE state waits while the output register is full and stalled.
// Synchronous reset clears all servers to idle, empties the FIFO and loads register defaults.
module multi_server_job_dispatcher (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [msjd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msjd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [msjd_pkg::TAG_BITS-1:0]     job_tag,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [msjd_pkg::KIND_W-1:0]       event_kind,
  output logic [msjd_pkg::IDX_OUT_W-1:0]    server_index,
  output logic [msjd_pkg::TAG_BITS-1:0]     departed_tag,
  output logic [msjd_pkg::TAG_BITS-1:0]     started_tag,
  output logic [msjd_pkg::WAIT_W-1:0]       waiting_count,
  output logic [msjd_pkg::BUSY_OUT_W-1:0]   busy_count
);
  import msjd_pkg::*;

  logic [SRV_CFG_W-1:0] servers_in_use;
  logic [LIMIT_W-1:0] queue_limit;
  logic limit_enabled;

  state_t state;
  logic [TAG_BITS-1:0] tag_r;
  logic [SRV_W-1:0] scan_idx;
  logic [SRV_W-1:0] free_idx;
  logic hit;
  logic free_hit;
  logic [SRV_W-1:0] last_idx;

  logic [QADDR_W-1:0] fifo_head;
  logic [QADDR_W-1:0] fifo_tail;
  logic [FILL_W-1:0] fifo_fill;
  logic [QADDR_W-1:0] fifo_head_next;
  logic [QADDR_W-1:0] fifo_tail_next;
  logic [FILL_W-1:0] fifo_fill_next;
  logic [TAG_BITS-1:0] head_data;
  logic fifo_we;

  srv_cmd_t srv_cmd;
  srv_stat_t srv_stat;
  logic [CNT_W-1:0] busy_cnt_next;

  logic in_xfer;
  logic out_load;
  logic queue_full;
  logic [KIND_W-1:0] kind_next;
  logic [SRV_W-1:0] sidx_next;
  logic [TAG_BITS-1:0] dep_next;
  logic [TAG_BITS-1:0] sta_next;

  msjd_servers u_servers (
    .clk           (clk),
    .rst           (rst),
    .rd_idx        (scan_idx),
    .tag           (tag_r),
    .cmd           (srv_cmd),
    .stat          (srv_stat),
    .busy_cnt_next (busy_cnt_next)
  );

  msjd_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_tail),
    .wdata (tag_r),
    .raddr (fifo_head),
    .rdata (head_data)
  );

  assign in_stall = (state != ST_IDLE);
  assign in_xfer = in_valid && !in_stall;
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    if (servers_in_use == '0) begin
      last_idx = '0;
    end else if (int'(servers_in_use) > MAX_SERVERS) begin
      last_idx = SRV_W'(MAX_SERVERS - 1);
    end else begin
      last_idx = SRV_W'(servers_in_use - 1'b1);
    end
  end

  assign queue_full = (int'(fifo_fill) >= QUEUE_DEPTH) ||
                      (limit_enabled && (int'(fifo_fill) >= int'(queue_limit)));

  assign fifo_head_next = (fifo_head == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : fifo_head + 1'b1;
  assign fifo_tail_next = (fifo_tail == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : fifo_tail + 1'b1;

  always_comb begin
    srv_cmd = '0;
    srv_cmd.idx = scan_idx;
    srv_cmd.job = tag_r;
    fifo_we = 1'b0;
    fifo_fill_next = fifo_fill;
    kind_next = EV_DROPPED;
    sidx_next = '0;
    dep_next = '0;
    sta_next = '0;
    if (hit) begin
      sidx_next = scan_idx;
      dep_next = tag_r;
      if (fifo_fill == '0) begin
        kind_next = EV_DEPART_IDLE;
        srv_cmd.we = out_load;
        srv_cmd.busy = 1'b0;
      end else begin
        kind_next = EV_DEPART_NEXT;
        sta_next = head_data;
        srv_cmd.we = out_load;
        srv_cmd.busy = 1'b1;
        srv_cmd.job = head_data;
        fifo_fill_next = fifo_fill - 1'b1;
      end
    end else if (free_hit) begin
      kind_next = EV_STARTED;
      sidx_next = free_idx;
      sta_next = tag_r;
      srv_cmd.we = out_load;
      srv_cmd.busy = 1'b1;
      srv_cmd.idx = free_idx;
    end else if (!queue_full) begin
      kind_next = EV_QUEUED;
      fifo_we = out_load;
      fifo_fill_next = fifo_fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      servers_in_use <= SRV_CFG_W'(1);
      queue_limit <= LIMIT_W'(64);
      limit_enabled <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SERVERS_IN_USE: servers_in_use <= cfg_data[SRV_CFG_W-1:0];
        CFG_QUEUE_LIMIT:    queue_limit <= cfg_data[LIMIT_W-1:0];
        CFG_LIMIT_ENABLED:  limit_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fifo_head <= '0;
      fifo_tail <= '0;
      fifo_fill <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (srv_stat.match || (scan_idx == last_idx)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
            fifo_fill <= fifo_fill_next;
            if (kind_next == EV_DEPART_NEXT) begin
              fifo_head <= fifo_head_next;
            end
            if (kind_next == EV_QUEUED) begin
              fifo_tail <= fifo_tail_next;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tag_r <= job_tag;
      scan_idx <= '0;
      hit <= 1'b0;
      free_hit <= 1'b0;
      free_idx <= '0;
    end else if (state == ST_SCAN) begin
      if (srv_stat.match) begin
        hit <= 1'b1;
      end else begin
        if (!srv_stat.busy && !free_hit) begin
          free_hit <= 1'b1;
          free_idx <= scan_idx;
        end
        if (scan_idx != last_idx) begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      event_kind <= kind_next;
      server_index <= IDX_OUT_W'(sidx_next);
      departed_tag <= dep_next;
      started_tag <= sta_next;
      waiting_count <= WAIT_W'(fifo_fill_next);
      busy_count <= BUSY_OUT_W'(busy_cnt_next);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(fifo_fill) <= QUEUE_DEPTH)
    else $error("waiting FIFO fill above its depth");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == ST_SCAN))
    else $error("accepted job did not start the server scan");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_kind == EV_STARTED || event_kind == EV_DEPART_NEXT))
      |-> (busy_count != '0))
    else $error("job started but no server reported busy");

endmodule

// File: src/msjd_ram.sv
module msjd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/msjd_servers.sv
module msjd_servers (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [msjd_pkg::SRV_W-1:0]     rd_idx,
  input  logic [msjd_pkg::TAG_BITS-1:0]  tag,
  input  msjd_pkg::srv_cmd_t             cmd,
  output msjd_pkg::srv_stat_t            stat,
  output logic [msjd_pkg::CNT_W-1:0]     busy_cnt_next
);
  import msjd_pkg::*;

  logic [MAX_SERVERS-1:0] server_busy;
  logic [TAG_BITS-1:0] server_job [MAX_SERVERS];
  logic [CNT_W-1:0] busy_cnt;
  logic set_one;
  logic clr_one;

  // One shared compare unit, stepped over the servers by the sequencer.
  assign stat.busy = server_busy[rd_idx];
  assign stat.match = server_busy[rd_idx] && (server_job[rd_idx] == tag);

  assign set_one = cmd.we && cmd.busy && !server_busy[cmd.idx];
  assign clr_one = cmd.we && !cmd.busy && server_busy[cmd.idx];

  always_comb begin
    busy_cnt_next = busy_cnt;
    if (set_one) begin
      busy_cnt_next = busy_cnt + 1'b1;
    end else if (clr_one) begin
      busy_cnt_next = busy_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      server_busy <= '0;
      busy_cnt <= '0;
    end else begin
      busy_cnt <= busy_cnt_next;
      if (cmd.we) begin
        server_busy[cmd.idx] <= cmd.busy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      server_job[cmd.idx] <= cmd.job;
    end
  end

endmodule

// File: test/tb_multi_server_job_dispatcher.sv
`timescale 1ns / 100ps

module tb_multi_server_job_dispatcher;
  import msjd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PHASES = 8;
  localparam int JOBS_PER_PHASE = 196;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_OUT_W-1:0] srv;
    logic [TAG_BITS-1:0] dep_tag;
    logic [TAG_BITS-1:0] sta_tag;
    logic [WAIT_W-1:0] waiting;
    logic [BUSY_OUT_W-1:0] busy;
  } dispatch_result_t;

  class dispatch_scoreboard;
    logic [SRV_CFG_W-1:0] servers_cfg;
    logic [LIMIT_W-1:0] limit_cfg;
    logic limit_on;
    logic srv_busy [MAX_SERVERS];
    logic [TAG_BITS-1:0] srv_job [MAX_SERVERS];
    logic [TAG_BITS-1:0] waiting_jobs [$];
    dispatch_result_t pending_events [$];
    int errors;

    function new();
      servers_cfg = SRV_CFG_W'(1);
      limit_cfg = LIMIT_W'(64);
      limit_on = 1'b0;
      foreach (srv_busy[i]) begin
        srv_busy[i] = 1'b0;
        srv_job[i] = '0;
      end
      errors = 0;
    endfunction

    function int active_count();
      if (servers_cfg == 0) return 1;
      if (servers_cfg > MAX_SERVERS) return MAX_SERVERS;
      return int'(servers_cfg);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SERVERS_IN_USE: servers_cfg = data[SRV_CFG_W-1:0];
        CFG_QUEUE_LIMIT: limit_cfg = data[LIMIT_W-1:0];
        CFG_LIMIT_ENABLED: limit_on = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    // Picks the tag of a busy server inside or beyond the active range.
    function bit pick_job(bit active_side, output logic [TAG_BITS-1:0] tag);
      logic [TAG_BITS-1:0] cand [$];
      int act;
      act = active_count();
      tag = '0;
      for (int i = 0; i < MAX_SERVERS; i++)
        if (srv_busy[i] && ((i < act) == active_side)) cand.push_back(srv_job[i]);
      if (cand.size() == 0) return 1'b0;
      tag = cand[$urandom_range(0, cand.size() - 1)];
      return 1'b1;
    endfunction

    function dispatch_result_t predict_dispatch(logic [TAG_BITS-1:0] tag);
      dispatch_result_t res;
      int act, hit, free_srv, n;
      logic full;
      res = '0;
      act = active_count();
      hit = -1;
      free_srv = -1;
      for (int i = 0; i < act; i++)
        if (hit < 0 && srv_busy[i] && srv_job[i] == tag) hit = i;
      if (hit >= 0) begin
        res.srv = IDX_OUT_W'(hit);
        res.dep_tag = tag;
        if (waiting_jobs.size() == 0) begin
          srv_busy[hit] = 1'b0;
          res.kind = EV_DEPART_IDLE;
        end else begin
          srv_job[hit] = waiting_jobs.pop_front();
          res.kind = EV_DEPART_NEXT;
          res.sta_tag = srv_job[hit];
        end
      end else begin
        for (int i = 0; i < act; i++)
          if (free_srv < 0 && !srv_busy[i]) free_srv = i;
        if (free_srv >= 0) begin
          srv_busy[free_srv] = 1'b1;
          srv_job[free_srv] = tag;
          res.kind = EV_STARTED;
          res.srv = IDX_OUT_W'(free_srv);
          res.sta_tag = tag;
        end else begin
          full = (waiting_jobs.size() >= QUEUE_DEPTH) ||
                 (limit_on && waiting_jobs.size() >= limit_cfg);
          if (full) begin
            res.kind = EV_DROPPED;
          end else begin
            waiting_jobs.push_back(tag);
            res.kind = EV_QUEUED;
          end
        end
      end
      res.waiting = WAIT_W'(waiting_jobs.size());
      n = 0;
      foreach (srv_busy[i]) if (srv_busy[i]) n++;
      res.busy = BUSY_OUT_W'(n);
      return res;
    endfunction

    function void note_job(logic [TAG_BITS-1:0] tag);
      pending_events.push_back(predict_dispatch(tag));
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("%0t ns mismatch: %s", $time, what);
    endtask

    task field_check(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_event(dispatch_result_t got);
      dispatch_result_t want;
      if (pending_events.size() == 0) begin
        report($sformatf("result of kind %0d with no job outstanding", got.kind));
        return;
      end
      want = pending_events.pop_front();
      field_check("event_kind", 32'(got.kind), 32'(want.kind));
      field_check("server_index", 32'(got.srv), 32'(want.srv));
      field_check("departed_tag", 32'(got.dep_tag), 32'(want.dep_tag));
      field_check("started_tag", 32'(got.sta_tag), 32'(want.sta_tag));
      field_check("waiting_count", 32'(got.waiting), 32'(want.waiting));
      field_check("busy_count", 32'(got.busy), 32'(want.busy));
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [TAG_BITS-1:0] job_tag;
  logic out_valid;
  logic out_stall;
  logic [KIND_W-1:0] event_kind;
  logic [IDX_OUT_W-1:0] server_index;
  logic [TAG_BITS-1:0] departed_tag;
  logic [TAG_BITS-1:0] started_tag;
  logic [WAIT_W-1:0] waiting_count;
  logic [BUSY_OUT_W-1:0] busy_count;

  dispatch_scoreboard sb;
  bit no_idle = 1'b0;
  bit hold_off_req = 1'b0;

  multi_server_job_dispatcher i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .job_tag(job_tag),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .event_kind(event_kind),
    .server_index(server_index),
    .departed_tag(departed_tag),
    .started_tag(started_tag),
    .waiting_count(waiting_count),
    .busy_count(busy_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin : monitor
    dispatch_result_t got;
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_job(job_tag);
      if (out_valid && !out_stall) begin
        got = {event_kind, server_index, departed_tag, started_tag, waiting_count, busy_count};
        sb.check_event(got);
      end
    end
  end

  initial begin : receiver
    int n;
    out_stall = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        n = idle_gap();
        out_stall <= (n > 0);
        if (n > 1) repeat (n - 1) @(negedge clk);
      end
    end
  end

  // All driving tasks start and end at a falling edge.
  task automatic send_job(logic [TAG_BITS-1:0] tag);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    job_tag <= tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [TAG_BITS-1:0] next_tag(int arrive_pct);
    logic [TAG_BITS-1:0] tag;
    int r;
    r = $urandom_range(0, 99);
    if (r >= arrive_pct && sb.pick_job(1'b1, tag)) return tag;
    r = $urandom_range(0, 99);
    if (r < 12) return TAG_BITS'($urandom_range(0, 7));
    if (r < 20 && sb.pick_job(1'b0, tag)) return tag;
    return TAG_BITS'($urandom_range(0, 65535));
  endfunction

  task automatic run_directed();
    send_job(16'h0000);
    send_job(16'hFFFF);
    send_job(16'h0000);
    send_job(16'hFFFF);
    send_job(16'h1234);
    send_job(16'h0055);
    send_job(16'h0055);
    send_job(16'h1234);
    send_job(16'h0055);
    send_job(16'h0055);
    drain();
    set_register(CFG_SERVERS_IN_USE, 7'd0);
    set_register(CFG_QUEUE_LIMIT, 7'd0);
    set_register(CFG_LIMIT_ENABLED, 7'd1);
    send_job(16'hA000);
    send_job(16'hA001);
    send_job(16'hA000);
    drain();
    set_register(CFG_SERVERS_IN_USE, 7'd15);
    set_register(CFG_QUEUE_LIMIT, 7'd2);
    for (int i = 0; i < MAX_SERVERS; i++) send_job(TAG_BITS'(16'h8000 + i));
    send_job(16'h0101);
    send_job(16'h0102);
    send_job(16'h0103);
    drain();
    set_register(CFG_SERVERS_IN_USE, 7'd2);
    set_register(CFG_UNUSED_INDEX, 7'h7F);
    send_job(16'h8005);
    send_job(16'h8001);
  endtask

  initial begin : stimulus
    int arrive_pct [RANDOM_PHASES] = '{85, 85, 60, 70, 50, 75, 65, 80};
    sb = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    job_tag = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      case (phase)
        0: begin
          set_register(CFG_SERVERS_IN_USE, 7'd8);
          set_register(CFG_QUEUE_LIMIT, 7'd64);
          set_register(CFG_LIMIT_ENABLED, 7'd0);
        end
        1: begin
          set_register(CFG_SERVERS_IN_USE, 7'd1);
          set_register(CFG_QUEUE_LIMIT, 7'd127);
          set_register(CFG_LIMIT_ENABLED, 7'd1);
        end
        2: begin
          set_register(CFG_SERVERS_IN_USE, 7'd0);
          set_register(CFG_QUEUE_LIMIT, 7'd0);
        end
        3: begin
          set_register(CFG_SERVERS_IN_USE, 7'd15);
          set_register(CFG_QUEUE_LIMIT, 7'd5);
        end
        default: begin
          set_register(CFG_QUEUE_LIMIT, CFG_DATA_W'($urandom_range(0, 127)));
          set_register(CFG_SERVERS_IN_USE, CFG_DATA_W'($urandom_range(0, 127)));
          set_register(CFG_LIMIT_ENABLED, CFG_DATA_W'($urandom_range(0, 127)));
          set_register(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom_range(0, 127)));
        end
      endcase
      for (int k = 0; k < JOBS_PER_PHASE; k++) begin
        no_idle = (k >= 60 && k < 100) || (phase == 4 && k >= 20 && k < 100);
        // The receiver holds off while the sender keeps offering, so the
        // block fills up and stalls its input.
        if (phase == 4 && k == 20) hold_off_req = 1'b1;
        if (phase == 6 && k == 120) begin
          in_valid <= 1'b0;
          while (sb.pending() != 0) @(negedge clk);
          @(negedge clk);
        end
        send_job(next_tag(arrive_pct[phase]));
      end
    end

    no_idle = 1'b0;
    drain();
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
